### rtl/mdds_pkg.sv
`timescale 1ns / 1ps

package mdds_pkg;

  // Motors that have request and result fields on the channels.
  localparam int IO_MOTORS = 2;

  localparam int REQ_W   = 16;
  localparam int DUTY_W  = 10;
  localparam int DEAD_W  = 8;
  localparam int REV_W   = 16;
  localparam int TRIP_W  = 2;
  localparam int SIGN_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [REV_W-1:0] REVERSAL_MAX = 16'hFFFF;

  // Direction codes, two's complement of -1, 0 and +1.
  localparam logic [SIGN_W-1:0] SIGN_NONE = 2'b00;
  localparam logic [SIGN_W-1:0] SIGN_POS  = 2'b01;
  localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'b11;

  localparam logic [TRIP_W-1:0] TRIP_NONE   = 2'd0;
  localparam logic [TRIP_W-1:0] TRIP_SENSOR = 2'd1;
  localparam logic [TRIP_W-1:0] TRIP_LOCKED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SLEW_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REV_DEADTIME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LIMIT  = 2'd2;

  localparam logic [DUTY_W-1:0] SLEW_STEP_RST  = 10'd25;
  localparam logic [DEAD_W-1:0] DEADTIME_RST   = 8'd10;
  localparam logic [DUTY_W-1:0] DUTY_LIMIT_RST = 10'd1000;

  typedef struct packed {
    logic [DUTY_W-1:0] slew_step;
    logic [DEAD_W-1:0] reverse_deadtime;
    logic [DUTY_W-1:0] duty_limit;
  } lane_cfg_t;

  typedef struct packed {
    logic step;
    logic stop;
  } lane_ctrl_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              pin;
    logic [REV_W-1:0]  reversals;
  } lane_res_t;

endpackage

### rtl/mdds_if.sv
`timescale 1ns / 1ps

interface mdds_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mdds_pkg::REQ_W-1:0]    left_request;
  logic signed [mdds_pkg::REQ_W-1:0]    right_request;
  logic                                 run_command;
  logic                                 sensor_ready;
  logic                                 run_unlocked;
  logic                                 protection_latched;

  modport source (
    output valid, left_request, right_request, run_command, sensor_ready,
           run_unlocked, protection_latched,
    input  ready
  );
  modport sink (
    input  valid, left_request, right_request, run_command, sensor_ready,
           run_unlocked, protection_latched,
    output ready
  );
endinterface

interface mdds_out_if;
  logic                          valid;
  logic                          ready;
  logic [mdds_pkg::DUTY_W-1:0]   left_duty;
  logic                          left_direction;
  logic [mdds_pkg::DUTY_W-1:0]   right_duty;
  logic                          right_direction;
  logic [mdds_pkg::REV_W-1:0]    left_reversals;
  logic [mdds_pkg::REV_W-1:0]    right_reversals;
  logic [mdds_pkg::TRIP_W-1:0]   trip_code;

  modport source (
    output valid, left_duty, left_direction, right_duty, right_direction,
           left_reversals, right_reversals, trip_code,
    input  ready
  );
  modport sink (
    input  valid, left_duty, left_direction, right_duty, right_direction,
           left_reversals, right_reversals, trip_code,
    output ready
  );
endinterface

### rtl/mdds_lane.sv
`timescale 1ns / 1ps

module mdds_lane (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mdds_pkg::lane_ctrl_t                ctrl,
  input  mdds_pkg::lane_cfg_t                 cfg,
  input  logic signed [mdds_pkg::REQ_W-1:0]   request,
  output mdds_pkg::lane_res_t                 res
);

  logic [mdds_pkg::DUTY_W-1:0] mag_r, mag_nxt;
  logic [mdds_pkg::SIGN_W-1:0] sign_r, sign_nxt;
  logic [mdds_pkg::DEAD_W-1:0] dead_r, dead_nxt;
  logic                        pin_r, pin_nxt;
  logic [mdds_pkg::REV_W-1:0]  rev_r, rev_nxt;

  logic [mdds_pkg::REQ_W-1:0]  req_u;
  logic [mdds_pkg::REQ_W-1:0]  abs_req;
  logic [mdds_pkg::DUTY_W-1:0] want_mag;
  logic [mdds_pkg::SIGN_W-1:0] want_sign;
  logic [mdds_pkg::SIGN_W-1:0] sign_eff;
  logic [mdds_pkg::DUTY_W:0]   up_sum;
  logic [mdds_pkg::DUTY_W-1:0] down_diff;
  logic [mdds_pkg::DUTY_W-1:0] duty;

  // The most negative request has magnitude 32768, which still fits unsigned.
  assign req_u   = unsigned'(request);
  assign abs_req = req_u[mdds_pkg::REQ_W-1] ? (~req_u + 16'd1) : req_u;
  assign want_mag = (abs_req > {6'd0, cfg.duty_limit}) ? cfg.duty_limit
                                                       : abs_req[mdds_pkg::DUTY_W-1:0];

  always_comb begin
    if (req_u == '0) begin
      want_sign = mdds_pkg::SIGN_NONE;
    end else if (req_u[mdds_pkg::REQ_W-1]) begin
      want_sign = mdds_pkg::SIGN_NEG;
    end else begin
      want_sign = mdds_pkg::SIGN_POS;
    end
  end

  assign sign_eff  = (sign_r == mdds_pkg::SIGN_NONE) ? want_sign : sign_r;
  assign up_sum    = {1'b0, mag_r} + {1'b0, cfg.slew_step};
  assign down_diff = mag_r - want_mag;

  always_comb begin
    mag_nxt  = mag_r;
    sign_nxt = sign_r;
    dead_nxt = dead_r;
    pin_nxt  = pin_r;
    rev_nxt  = rev_r;
    duty     = '0;
    priority if (ctrl.stop) begin
      mag_nxt  = '0;
      sign_nxt = mdds_pkg::SIGN_NONE;
      dead_nxt = '0;
      pin_nxt  = 1'b0;
    end else if (dead_r != '0) begin
      // On the last dead-time tick the direction becomes whatever is asked now.
      dead_nxt = dead_r - 8'd1;
      mag_nxt  = '0;
      if (dead_r == 8'd1) begin
        sign_nxt = want_sign;
      end
    end else if (want_sign != mdds_pkg::SIGN_NONE && sign_r != mdds_pkg::SIGN_NONE &&
                 want_sign != sign_r) begin
      dead_nxt = cfg.reverse_deadtime;
      mag_nxt  = '0;
      if (rev_r != mdds_pkg::REVERSAL_MAX) begin
        rev_nxt = rev_r + 16'd1;
      end
    end else if (want_sign == mdds_pkg::SIGN_NONE) begin
      mag_nxt = '0;
    end else begin
      sign_nxt = sign_eff;
      if (mag_r < want_mag) begin
        mag_nxt = (up_sum > {1'b0, want_mag}) ? want_mag : up_sum[mdds_pkg::DUTY_W-1:0];
      end else if (mag_r > want_mag) begin
        mag_nxt = (down_diff <= cfg.slew_step) ? want_mag : (mag_r - cfg.slew_step);
      end
      pin_nxt = (sign_eff == mdds_pkg::SIGN_POS);
      duty    = mag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r  <= '0;
      sign_r <= mdds_pkg::SIGN_NONE;
      dead_r <= '0;
      pin_r  <= 1'b0;
      rev_r  <= '0;
    end else if (ctrl.step) begin
      mag_r  <= mag_nxt;
      sign_r <= sign_nxt;
      dead_r <= dead_nxt;
      pin_r  <= pin_nxt;
      rev_r  <= rev_nxt;
    end
  end

  assign res.duty      = duty;
  assign res.pin       = pin_nxt;
  assign res.reversals = rev_nxt;

endmodule

### rtl/motor_drive_deadtime_slew.sv
`timescale 1ns / 1ps
// Each accepted item passes through the input register and then the per-motor update
// into the result register.
// Throughput: one item per cycle while the result side keeps taking results.
// Reset (synchronous, rst_n low): channels empty, motor state and reversal
// counts cleared, registers back to slew 25, dead time 10, limit 1000.

module motor_drive_deadtime_slew #(
  parameter int MOTOR_COUNT = 2
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  mdds_in_if.sink                              in_ch,
  mdds_out_if.source                           out_ch,
  input  logic                                 cfg_we,
  input  logic [mdds_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mdds_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  mdds_pkg::lane_cfg_t cfg_r;

  logic                                s1_valid_r;
  logic signed [mdds_pkg::REQ_W-1:0]   s1_req_r [mdds_pkg::IO_MOTORS];
  logic                                s1_run_r, s1_ready_r, s1_unlocked_r, s1_latched_r;

  logic                                out_valid_r;
  logic [mdds_pkg::DUTY_W-1:0]         out_duty_r [mdds_pkg::IO_MOTORS];
  logic                                out_pin_r  [mdds_pkg::IO_MOTORS];
  logic [mdds_pkg::REV_W-1:0]          out_rev_r  [mdds_pkg::IO_MOTORS];
  logic [mdds_pkg::TRIP_W-1:0]         out_trip_r;

  logic                                advance, take_in, process;
  logic                                stop;
  logic [mdds_pkg::TRIP_W-1:0]         trip;
  mdds_pkg::lane_ctrl_t                lane_ctrl;
  mdds_pkg::lane_res_t                 lane_res [mdds_pkg::IO_MOTORS];

  assign advance  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || advance;
  assign take_in  = in_ch.valid && in_ch.ready;
  assign process  = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slew_step        <= mdds_pkg::SLEW_STEP_RST;
      cfg_r.reverse_deadtime <= mdds_pkg::DEADTIME_RST;
      cfg_r.duty_limit       <= mdds_pkg::DUTY_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mdds_pkg::CFG_SLEW_STEP:    cfg_r.slew_step <= cfg_wdata;
        mdds_pkg::CFG_REV_DEADTIME: cfg_r.reverse_deadtime <= cfg_wdata[mdds_pkg::DEAD_W-1:0];
        mdds_pkg::CFG_DUTY_LIMIT:   cfg_r.duty_limit <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      s1_req_r[0]   <= in_ch.left_request;
      s1_req_r[1]   <= in_ch.right_request;
      s1_run_r      <= in_ch.run_command;
      s1_ready_r    <= in_ch.sensor_ready;
      s1_unlocked_r <= in_ch.run_unlocked;
      s1_latched_r  <= in_ch.protection_latched;
    end
  end

  assign stop = !s1_run_r || !s1_ready_r || !s1_unlocked_r || s1_latched_r;

  always_comb begin
    priority if (!s1_run_r) begin
      trip = mdds_pkg::TRIP_NONE;
    end else if (!s1_ready_r) begin
      trip = mdds_pkg::TRIP_SENSOR;
    end else if (!s1_unlocked_r) begin
      trip = mdds_pkg::TRIP_LOCKED;
    end else begin
      trip = mdds_pkg::TRIP_NONE;
    end
  end

  assign lane_ctrl.step = process;
  assign lane_ctrl.stop = stop;

  for (genvar g = 0; g < mdds_pkg::IO_MOTORS; g++) begin : g_motor
    if (g < MOTOR_COUNT) begin : g_lane
      mdds_lane u_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lane_ctrl),
        .cfg     (cfg_r),
        .request (s1_req_r[g]),
        .res     (lane_res[g])
      );
    end else begin : g_absent
      // A motor beyond the configured count is not driven and reads as zero.
      assign lane_res[g] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      for (int m = 0; m < mdds_pkg::IO_MOTORS; m++) begin
        out_duty_r[m] <= lane_res[m].duty;
        out_pin_r[m]  <= lane_res[m].pin;
        out_rev_r[m]  <= lane_res[m].reversals;
      end
      out_trip_r <= trip;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.left_duty       = out_duty_r[0];
  assign out_ch.left_direction  = out_pin_r[0];
  assign out_ch.right_duty      = out_duty_r[1];
  assign out_ch.right_direction = out_pin_r[1];
  assign out_ch.left_reversals  = out_rev_r[0];
  assign out_ch.right_reversals = out_rev_r[1];
  assign out_ch.trip_code       = out_trip_r;

`ifndef NO_ASSERTIONS
  // A trip stops the drive: no duty and no direction on the same result.
  a_trip_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_trip_r != mdds_pkg::TRIP_NONE |->
      out_duty_r[0] == '0 && out_duty_r[1] == '0 && !out_pin_r[0] && !out_pin_r[1])
    else $error("trip code with nonzero drive");

  // A result that waits keeps its fields until it is taken.
  a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(out_trip_r) &&
      $stable(out_duty_r[0]) && $stable(out_duty_r[1]))
    else $error("waiting result changed");

  // The input stage drains into an empty or departing result register.
  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && advance |=> out_valid_r)
    else $error("item lost between stages");
`endif

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  // Flag nibble order: run_command, sensor_ready, run_unlocked, protection_latched.
  localparam logic [3:0] FLAGS_GO        = 4'b1110;
  localparam logic [3:0] FLAGS_OFF       = 4'b0111;
  localparam logic [3:0] FLAGS_NO_SENSOR = 4'b1010;
  localparam logic [3:0] FLAGS_LOCKED    = 4'b1100;
  localparam logic [3:0] FLAGS_LATCHED   = 4'b1111;

  localparam int PHASES       = 10;
  localparam int PHASE_RANDOM = 160;
  localparam int PHASE_TAIL   = 30;
  localparam int REV_TICKS    = 40;
  localparam int PARK_AT      = 500;
  localparam int PARK_CYCLES  = 250;

  typedef struct packed {
    logic signed [mdds_pkg::REQ_W-1:0] left;
    logic signed [mdds_pkg::REQ_W-1:0] right;
    logic                              run;
    logic                              sensor_ok;
    logic                              unlocked;
    logic                              prot_latched;
  } tick_in_t;

  typedef struct packed {
    logic [mdds_pkg::DUTY_W-1:0] left_duty;
    logic                        left_dir;
    logic [mdds_pkg::DUTY_W-1:0] right_duty;
    logic                        right_dir;
    logic [mdds_pkg::REV_W-1:0]  left_revs;
    logic [mdds_pkg::REV_W-1:0]  right_revs;
    logic [mdds_pkg::TRIP_W-1:0] trip;
  } tick_out_t;

  typedef struct {
    logic signed [mdds_pkg::REQ_W-1:0] left;
    logic signed [mdds_pkg::REQ_W-1:0] right;
    logic [3:0]                        flags;
    int                                reps;
    bit                                typed;
    tick_out_t                         want;
  } dir_row_t;

  localparam tick_out_t STOPPED = '0;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [mdds_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mdds_pkg::CFG_DATA_W-1:0] cfg_wdata;

  mdds_in_if in_bus ();
  mdds_out_if out_bus ();

  motor_drive_deadtime_slew dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Drive state as the block should hold it.
  logic [mdds_pkg::DUTY_W-1:0] slew_cfg;
  logic [mdds_pkg::DEAD_W-1:0] dead_cfg;
  logic [mdds_pkg::DUTY_W-1:0] limit_cfg;
  logic [mdds_pkg::DUTY_W-1:0] mag_st  [2];
  logic [mdds_pkg::SIGN_W-1:0] sign_st [2];
  logic [mdds_pkg::SIGN_W-1:0] pend_st [2];
  logic [mdds_pkg::DEAD_W-1:0] dead_st [2];
  logic                        pin_st  [2];
  logic [mdds_pkg::REV_W-1:0]  revs_st [2];

  tick_out_t expected_ticks [$];
  int errors = 0;
  int results_seen = 0;
  bit steady = 1'b0;

  logic signed [mdds_pkg::REQ_W-1:0] hold_req [2];
  int hold_cnt [2] = '{0, 0};

  int phase_slew [PHASES] = '{40, 300, 1023, 0, 1, 1023, 0, 12, 0, 0};
  int phase_dead [PHASES] = '{6, 0, 255, 3, 1, 0, 0, 2, 0, 0};
  int phase_lim  [PHASES] = '{1023, 200, 1023, 600, 1, 0, 0, 900, 0, 0};

  function automatic void halt_motors();
    int m;
    for (m = 0; m < 2; m++) begin
      mag_st[m]  = '0;
      sign_st[m] = mdds_pkg::SIGN_NONE;
      pend_st[m] = mdds_pkg::SIGN_NONE;
      dead_st[m] = '0;
      pin_st[m]  = 1'b0;
    end
  endfunction

  function automatic logic [mdds_pkg::DUTY_W-1:0] motor_tick(
      input int m, input logic signed [mdds_pkg::REQ_W-1:0] req);
    logic [mdds_pkg::SIGN_W-1:0] want_sign;
    int want_mag;
    int cur;
    int slew;
    slew = int'(slew_cfg);
    if (req == 0) begin
      want_sign = mdds_pkg::SIGN_NONE;
      want_mag  = 0;
    end else if (req < 0) begin
      want_sign = mdds_pkg::SIGN_NEG;
      want_mag  = -int'(req);
    end else begin
      want_sign = mdds_pkg::SIGN_POS;
      want_mag  = int'(req);
    end
    if (want_mag > int'(limit_cfg))
      want_mag = int'(limit_cfg);

    // Dead time runs out whatever is requested; the last request picks the new sign.
    if (dead_st[m] != 0) begin
      pend_st[m] = want_sign;
      dead_st[m] = dead_st[m] - 1'b1;
      mag_st[m]  = '0;
      if (dead_st[m] == 0)
        sign_st[m] = pend_st[m];
      return '0;
    end

    if (want_sign != mdds_pkg::SIGN_NONE && sign_st[m] != mdds_pkg::SIGN_NONE &&
        want_sign != sign_st[m]) begin
      pend_st[m] = want_sign;
      dead_st[m] = dead_cfg;
      mag_st[m]  = '0;
      if (revs_st[m] != mdds_pkg::REVERSAL_MAX)
        revs_st[m] = revs_st[m] + 1'b1;
      return '0;
    end

    if (want_sign == mdds_pkg::SIGN_NONE) begin
      mag_st[m] = '0;
      return '0;
    end

    if (sign_st[m] == mdds_pkg::SIGN_NONE)
      sign_st[m] = want_sign;

    cur = int'(mag_st[m]);
    if (cur < want_mag)
      cur = (cur + slew > want_mag) ? want_mag : cur + slew;
    else if (cur > want_mag)
      cur = (cur - want_mag <= slew) ? want_mag : cur - slew;
    mag_st[m] = mdds_pkg::DUTY_W'(cur);
    pin_st[m] = (sign_st[m] == mdds_pkg::SIGN_POS);
    return mag_st[m];
  endfunction

  function automatic tick_out_t predict_tick(input tick_in_t t);
    tick_out_t r;
    r = '0;
    if (!t.run) begin
      halt_motors();
    end else if (!t.sensor_ok) begin
      r.trip = mdds_pkg::TRIP_SENSOR;
      halt_motors();
    end else if (!t.unlocked) begin
      r.trip = mdds_pkg::TRIP_LOCKED;
      halt_motors();
    end else if (t.prot_latched) begin
      halt_motors();
    end else begin
      r.left_duty  = motor_tick(0, t.left);
      r.right_duty = motor_tick(1, t.right);
    end
    r.left_dir   = pin_st[0];
    r.right_dir  = pin_st[1];
    r.left_revs  = revs_st[0];
    r.right_revs = revs_st[1];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    if (r < 98)
      return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Requests are held for a while so that ramps, reversals and dead time play out,
  // with a sprinkle of one-off noise values and broken flag sets.
  function automatic tick_in_t random_item();
    tick_in_t t;
    int m;
    int r;
    logic signed [mdds_pkg::REQ_W-1:0] v [2];
    for (m = 0; m < 2; m++) begin
      if (hold_cnt[m] == 0) begin
        r = $urandom_range(0, 99);
        if (r < 10)
          hold_req[m] = '0;
        else if (r < 25)
          hold_req[m] = mdds_pkg::REQ_W'($urandom);
        else begin
          hold_req[m] = mdds_pkg::REQ_W'($urandom_range(1, 1100));
          if ($urandom_range(0, 1) == 1)
            hold_req[m] = -hold_req[m];
        end
        hold_cnt[m] = $urandom_range(1, 40);
      end
      hold_cnt[m]--;
      v[m] = ($urandom_range(0, 99) < 5) ? mdds_pkg::REQ_W'($urandom) : hold_req[m];
    end
    t.left  = v[0];
    t.right = v[1];
    if ($urandom_range(0, 99) < 88)
      {t.run, t.sensor_ok, t.unlocked, t.prot_latched} = FLAGS_GO;
    else
      {t.run, t.sensor_ok, t.unlocked, t.prot_latched} = 4'($urandom_range(0, 15));
    return t;
  endfunction

  task automatic send_tick(input tick_in_t t, input bit typed, input tick_out_t want);
    int gap;
    tick_out_t pred;
    gap = steady ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid              <= 1'b1;
    in_bus.left_request       <= t.left;
    in_bus.right_request      <= t.right;
    in_bus.run_command        <= t.run;
    in_bus.sensor_ready       <= t.sensor_ok;
    in_bus.run_unlocked       <= t.unlocked;
    in_bus.protection_latched <= t.prot_latched;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    pred = predict_tick(t);
    expected_ticks.push_back(typed ? want : pred);
  endtask

  task automatic settle();
    @(negedge clk) in_bus.valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input int slew, input int dead, input int lim);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= mdds_pkg::CFG_SLEW_STEP;
    cfg_wdata <= mdds_pkg::CFG_DATA_W'(slew);
    @(negedge clk);
    cfg_index <= mdds_pkg::CFG_REV_DEADTIME;
    cfg_wdata <= mdds_pkg::CFG_DATA_W'(dead);
    @(negedge clk);
    cfg_index <= mdds_pkg::CFG_DUTY_LIMIT;
    cfg_wdata <= mdds_pkg::CFG_DATA_W'(lim);
    @(negedge clk);
    cfg_we <= 1'b0;
    slew_cfg  = mdds_pkg::DUTY_W'(slew);
    dead_cfg  = mdds_pkg::DEAD_W'(dead);
    limit_cfg = mdds_pkg::DUTY_W'(lim);
  endtask

  // Result side: random stalls, one long hold-off once the block is well under way.
  int stall_left = 0;
  int park_left = 0;
  bit parked = 1'b0;

  always @(negedge clk) begin
    if (!parked && results_seen >= PARK_AT) begin
      parked = 1'b1;
      park_left = PARK_CYCLES;
    end
    if (park_left > 0) begin
      park_left--;
      out_bus.ready <= 1'b0;
    end else if (steady) begin
      out_bus.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_bus.ready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      out_bus.ready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin : result_check
    tick_out_t got;
    tick_out_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      results_seen++;
      got.left_duty  = out_bus.left_duty;
      got.left_dir   = out_bus.left_direction;
      got.right_duty = out_bus.right_duty;
      got.right_dir  = out_bus.right_direction;
      got.left_revs  = out_bus.left_reversals;
      got.right_revs = out_bus.right_reversals;
      got.trip       = out_bus.trip_code;
      if (expected_ticks.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: duty %0d/%0d dir %0b/%0b revs %0d/%0d trip %0d",
                   got.left_duty, got.right_duty, got.left_dir, got.right_dir,
                   got.left_revs, got.right_revs, got.trip);
      end else begin
        want = expected_ticks.pop_front();
        if (got.left_duty !== want.left_duty || got.left_dir !== want.left_dir ||
            got.right_duty !== want.right_duty || got.right_dir !== want.right_dir ||
            got.left_revs !== want.left_revs || got.right_revs !== want.right_revs ||
            got.trip !== want.trip) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch at result %0d:", results_seen);
            $display("  expected duty %0d/%0d dir %0b/%0b revs %0d/%0d trip %0d",
                     want.left_duty, want.right_duty, want.left_dir, want.right_dir,
                     want.left_revs, want.right_revs, want.trip);
            $display("  actual   duty %0d/%0d dir %0b/%0b revs %0d/%0d trip %0d",
                     got.left_duty, got.right_duty, got.left_dir, got.right_dir,
                     got.left_revs, got.right_revs, got.trip);
          end
        end
      end
    end
  end

  dir_row_t directed_rows [12];

  initial begin
    int i;
    int p;
    tick_in_t t;

    rst_n                     = 1'b0;
    cfg_we                    = 1'b0;
    cfg_index                 = '0;
    cfg_wdata                 = '0;
    in_bus.valid              = 1'b0;
    in_bus.left_request       = '0;
    in_bus.right_request      = '0;
    in_bus.run_command        = 1'b0;
    in_bus.sensor_ready       = 1'b0;
    in_bus.run_unlocked       = 1'b0;
    in_bus.protection_latched = 1'b0;
    out_bus.ready             = 1'b0;

    slew_cfg  = mdds_pkg::SLEW_STEP_RST;
    dead_cfg  = mdds_pkg::DEADTIME_RST;
    limit_cfg = mdds_pkg::DUTY_LIMIT_RST;
    halt_motors();
    revs_st[0] = '0;
    revs_st[1] = '0;

    // Stop priorities first, then a ramp, a zero request holding the pins, a reversal
    // on both motors, its dead time, the dead time ending on a zero request,
    // a fresh start from no direction, and a protection stop that keeps the counts.
    directed_rows = '{
      '{16'sd32767, 16'sh8000, FLAGS_OFF, 1, 1'b1, STOPPED},
      '{16'sd32767, 16'sh8000, FLAGS_NO_SENSOR, 1, 1'b1,
        '{10'd0, 1'b0, 10'd0, 1'b0, 16'd0, 16'd0, mdds_pkg::TRIP_SENSOR}},
      '{16'sd32767, 16'sh8000, FLAGS_LOCKED, 1, 1'b1,
        '{10'd0, 1'b0, 10'd0, 1'b0, 16'd0, 16'd0, mdds_pkg::TRIP_LOCKED}},
      '{16'sd32767, 16'sh8000, FLAGS_LATCHED, 1, 1'b1, STOPPED},
      '{16'sd32767, 16'sh8000, FLAGS_GO, 1, 1'b1,
        '{10'd25, 1'b1, 10'd25, 1'b0, 16'd0, 16'd0, mdds_pkg::TRIP_NONE}},
      '{16'sd32767, 16'sh8000, FLAGS_GO, 1, 1'b0, STOPPED},
      '{16'sd0, 16'sd0, FLAGS_GO, 1, 1'b0, STOPPED},
      '{-16'sd1000, 16'sd1, FLAGS_GO, 1, 1'b0, STOPPED},
      '{-16'sd5, 16'sd5, FLAGS_GO, 8, 1'b0, STOPPED},
      '{16'sd0, 16'sd0, FLAGS_GO, 2, 1'b0, STOPPED},
      '{-16'sd1, 16'sd1, FLAGS_GO, 1, 1'b0, STOPPED},
      '{16'sd100, -16'sd100, FLAGS_LATCHED, 1, 1'b0, STOPPED}
    };

    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    for (i = 0; i < 12; i++) begin
      t.left  = directed_rows[i].left;
      t.right = directed_rows[i].right;
      {t.run, t.sensor_ok, t.unlocked, t.prot_latched} = directed_rows[i].flags;
      repeat (directed_rows[i].reps)
        send_tick(t, directed_rows[i].typed, directed_rows[i].want);
    end

    for (p = 0; p < PHASES; p++) begin
      settle();
      if (p >= 8)
        set_config($urandom_range(0, 1023), $urandom_range(0, 255),
                   $urandom_range(0, 1023));
      else
        set_config(phase_slew[p], phase_dead[p], phase_lim[p]);
      steady = (p == 7);
      for (i = 0; i < PHASE_RANDOM; i++)
        send_tick(random_item(), 1'b0, STOPPED);
      // A long steady request to close the phase leaves the motors at speed, so
      // that a lower limit in the next phase has to ramp down.
      t.left  = ($urandom_range(0, 1) == 1) ? 16'sd1023 : -16'sd1023;
      t.right = ($urandom_range(0, 1) == 1) ? 16'sd1023 : -16'sd1023;
      {t.run, t.sensor_ok, t.unlocked, t.prot_latched} = FLAGS_GO;
      repeat (PHASE_TAIL) send_tick(t, 1'b0, STOPPED);
    end

    // With no dead time a reversal request counts on every tick and the
    // direction never changes.
    settle();
    set_config(25, 0, 1000);
    steady = 1'b1;
    {t.run, t.sensor_ok, t.unlocked, t.prot_latched} = FLAGS_OFF;
    send_tick(t, 1'b0, STOPPED);
    {t.run, t.sensor_ok, t.unlocked, t.prot_latched} = FLAGS_GO;
    t.left  = 16'sd1;
    t.right = -16'sd1;
    send_tick(t, 1'b0, STOPPED);
    t.left  = -16'sd1;
    t.right = 16'sd1;
    repeat (REV_TICKS) send_tick(t, 1'b0, STOPPED);

    settle();
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
